/* rtl/core/fir_lp_pkg.sv */
// Shared types, constants and the coefficient ROM of the low-pass FIR filter.
package fir_lp_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int WEIGHT_W  = 20;
   localparam int FRAC_BITS = 20;
   localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
   localparam int ACC_W     = PROD_W + 8;
   localparam int TAP_IDX_W = 8;
   localparam int ROM_TAPS  = 145;
   localparam int ROM_HALF  = 73;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   localparam logic [WEIGHT_W-1:0] WEIGHT_HALF [ROM_HALF] = '{
      20'd144,   20'd165,   20'd188,   20'd214,   20'd244,   20'd279,   20'd318,
      20'd364,   20'd416,   20'd475,   20'd542,   20'd617,   20'd702,   20'd795,
      20'd899,   20'd1014,  20'd1139,  20'd1276,  20'd1425,  20'd1586,  20'd1760,
      20'd1946,  20'd2145,  20'd2357,  20'd2582,  20'd2820,  20'd3071,  20'd3334,
      20'd3611,  20'd3899,  20'd4200,  20'd4512,  20'd4835,  20'd5169,  20'd5512,
      20'd5865,  20'd6227,  20'd6597,  20'd6973,  20'd7356,  20'd7744,  20'd8136,
      20'd8531,  20'd8928,  20'd9327,  20'd9725,  20'd10123, 20'd10518, 20'd10910,
      20'd11297, 20'd11678, 20'd12052, 20'd12419, 20'd12776, 20'd13122, 20'd13457,
      20'd13779, 20'd14088, 20'd14382, 20'd14660, 20'd14922, 20'd15166, 20'd15392,
      20'd15598, 20'd15785, 20'd15952, 20'd16097, 20'd16221, 20'd16323, 20'd16403,
      20'd16460, 20'd16494, 20'd16506
   };

   typedef struct packed {
      logic load;
      logic rotate;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } mac_ctl_type;

   function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [TAP_IDX_W-1:0] n);
      logic [TAP_IDX_W-1:0] mirror;
      mirror = TAP_IDX_W'(ROM_TAPS - 1) - n;
      if (n >= TAP_IDX_W'(ROM_TAPS)) begin
         return '0;
      end else if (n < TAP_IDX_W'(ROM_HALF)) begin
         return WEIGHT_HALF[n[6:0]];
      end else begin
         return WEIGHT_HALF[mirror[6:0]];
      end
   endfunction

endpackage

/* rtl/core/fir_lp_cell.sv */
// One delay-line cell: holds a sample, shifts on a new beat and rotates during the sum.
module fir_lp_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fir_lp_pkg::cell_ctl_type              ctl,
   input  logic signed [fir_lp_pkg::SAMPLE_W-1:0] shift_in,
   input  logic signed [fir_lp_pkg::SAMPLE_W-1:0] rot_in,
   output logic signed [fir_lp_pkg::SAMPLE_W-1:0] data_out
);

   logic signed [fir_lp_pkg::SAMPLE_W-1:0] data_ff;
   logic signed [fir_lp_pkg::SAMPLE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = shift_in;
      end else if (ctl.rotate) begin
         data_in = rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

/* rtl/core/fir_lp_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation of the final sum.
module fir_lp_mac (
   input  logic                                      clock,
   input  logic                                      reset,
   input  fir_lp_pkg::mac_ctl_type                   ctl,
   input  logic signed [fir_lp_pkg::SAMPLE_W-1:0]     sample,
   input  logic [fir_lp_pkg::TAP_IDX_W-1:0]           tap,
   output logic signed [fir_lp_pkg::SAMPLE_W-1:0]     result
);

   localparam int ACC_W = fir_lp_pkg::ACC_W;
   localparam int PROD_W = fir_lp_pkg::PROD_W;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic                     prod_vld_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [fir_lp_pkg::WEIGHT_W:0] weight;
   logic signed [ACC_W:0]    biased;
   logic signed [ACC_W:0]    rounded;

   assign weight  = $signed({1'b0, fir_lp_pkg::tap_weight(tap)});
   assign prod_in = PROD_W'(sample) * PROD_W'(weight);

   always_comb begin
      prod_vld_in = ctl.enable;
      acc_in      = acc_ff;
      if (ctl.clear) begin
         prod_vld_in = 1'b0;
         acc_in      = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Half an LSB is added before the arithmetic shift, so ties round upwards.
   assign biased  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(1 << (fir_lp_pkg::FRAC_BITS - 1));
   assign rounded = biased >>> fir_lp_pkg::FRAC_BITS;

   always_comb begin
      if (rounded > (ACC_W+1)'(fir_lp_pkg::SAMPLE_MAX)) begin
         result = fir_lp_pkg::SAMPLE_MAX;
      end else if (rounded < (ACC_W+1)'(fir_lp_pkg::SAMPLE_MIN)) begin
         result = fir_lp_pkg::SAMPLE_MIN;
      end else begin
         result = rounded[fir_lp_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

/* rtl/core/fir_lowpass_filter_top.sv */
// Top level of the low-pass FIR filter: ring of delay cells, sequencer and output register.
// An accepted beat drives the sequencer through RUN over every tap, then DRAIN and FINISH;
// since the single MAC visits every tap, no new beat is taken until it is back in IDLE;
// a result still held by rsp_stall stretches the finish cycle until it leaves.
// A new beat is taken while the previous result still waits in the output register.
// Reset clears every delay cell to zero and empties the output register.
module fir_lowpass_filter_top #(
   parameter int TAPS = 145
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fir_lp_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fir_lp_pkg::SAMPLE_W-1:0] rsp_filtered
);

   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [CNT_W-1:0] tap_cnt_ff;
   logic [CNT_W-1:0] tap_cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic signed [fir_lp_pkg::SAMPLE_W-1:0] rsp_data_ff;
   logic signed [fir_lp_pkg::SAMPLE_W-1:0] rsp_data_in;
   logic signed [fir_lp_pkg::SAMPLE_W-1:0] mac_result;
   logic signed [fir_lp_pkg::SAMPLE_W-1:0] cell_data [TAPS];

   fir_lp_pkg::cell_ctl_type cell_ctl;
   fir_lp_pkg::mac_ctl_type  mac_ctl;

   logic req_accept;
   logic rsp_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign cell_ctl.load   = req_accept;
   assign cell_ctl.rotate = (state_ff == ST_RUN);
   assign mac_ctl.clear   = req_accept;
   assign mac_ctl.enable  = (state_ff == ST_RUN);

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % TAPS;
      if (k == 0) begin : g_head
         fir_lp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .shift_in (req_sample),
            .rot_in   (cell_data[NEXT]),
            .data_out (cell_data[k])
         );
      end else begin : g_body
         fir_lp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .shift_in (cell_data[k-1]),
            .rot_in   (cell_data[NEXT]),
            .data_out (cell_data[k])
         );
      end
   end

   fir_lp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (cell_data[0]),
      .tap    (fir_lp_pkg::TAP_IDX_W'(tap_cnt_ff)),
      .result (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      tap_cnt_in   = tap_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in   = ST_RUN;
               tap_cnt_in = '0;
            end
         end
         ST_RUN: begin
            tap_cnt_in = tap_cnt_ff + 1'b1;
            if (tap_cnt_ff == CNT_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_cnt_ff   <= tap_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;

   a_accept_starts_sum : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN) && (tap_cnt_ff == '0))
      else $error("accepted beat did not start the tap sweep");

   a_drain_to_finish : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_FINISH))
      else $error("drain cycle not followed by finish");

   a_finish_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished sum not presented on the result channel");

   a_run_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (tap_cnt_ff <= CNT_W'(TAPS - 1)))
      else $error("tap counter ran past the last tap");

endmodule

/* tb/tb_fir_lowpass_filter_top.sv */
// Self-checking testbench for the 145-tap low-pass FIR filter with random idling on both sides.
module tb_fir_lowpass_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = fir_lp_pkg::SAMPLE_W;
   localparam int TAP_COUNT    = 145;
   localparam int HALF_TAPS    = 73;
   localparam int STUCK_LIMIT  = 5000;
   localparam int SETTLE_WAIT  = 160;
   localparam int IDLE_PERCENT = 15;
   localparam int REPORT_MAX   = 10;

   localparam int unsigned LOWPASS_HALF [HALF_TAPS] = '{
      144, 165, 188, 214, 244, 279, 318, 364, 416, 475,
      542, 617, 702, 795, 899, 1014, 1139, 1276, 1425, 1586,
      1760, 1946, 2145, 2357, 2582, 2820, 3071, 3334, 3611, 3899,
      4200, 4512, 4835, 5169, 5512, 5865, 6227, 6597, 6973, 7356,
      7744, 8136, 8531, 8928, 9327, 9725, 10123, 10518, 10910, 11297,
      11678, 12052, 12419, 12776, 13122, 13457, 13779, 14088, 14382, 14660,
      14922, 15166, 15392, 15598, 15785, 15952, 16097, 16221, 16323, 16403,
      16460, 16494, 16506
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_filtered;

   logic signed [SAMPLE_W-1:0] sample_history [TAP_COUNT];
   int unsigned                history_head;
   logic signed [SAMPLE_W-1:0] expected_filtered [$];
   logic                       no_idle;
   int unsigned                mismatches;
   int unsigned                stuck_cycles;

   fir_lowpass_filter_top #(
      .TAPS(TAP_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_filtered(rsp_filtered)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] sample
   );
      longint      acc;
      longint      rounded;
      longint      weight;
      int unsigned idx;
      sample_history[history_head] = sample;
      acc = 0;
      idx = history_head;
      for (int n = 0; n < TAP_COUNT; n++) begin
         weight = (n < HALF_TAPS) ? longint'(LOWPASS_HALF[n])
                                  : longint'(LOWPASS_HALF[TAP_COUNT - 1 - n]);
         acc += weight * longint'(sample_history[idx]);
         idx = (idx == 0) ? TAP_COUNT - 1 : idx - 1;
      end
      rounded = (acc + 64'sd524288) >>> 20;
      if (rounded > 64'sd8388607) begin
         rounded = 64'sd8388607;
      end
      if (rounded < -64'sd8388608) begin
         rounded = -64'sd8388608;
      end
      history_head = (history_head == TAP_COUNT - 1) ? 0 : history_head + 1;
      return SAMPLE_W'(rounded);
   endfunction

   function automatic bit take_idle();
      return !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      while (take_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_filtered.push_back(filter_sample(sample));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_filtered.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Straight after reset the delay line is empty, so these two beats land exactly on
   // half an LSB, the first positive and the second negative.
   task automatic test_rounding_ties();
      send_sample(24'sd32768);
      send_sample(-24'sd92160);
   endtask

   task automatic test_extremes();
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sd0);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sh800000);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      send_sample(24'sh555555);
      send_sample(24'shAAAAAA);
      send_sample(24'shFFFFFF);
      send_sample(24'sh000001);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
   endtask

   // Long runs of full-scale samples fill the whole delay line and push the sum to its limits.
   task automatic test_saturation();
      no_idle = 1'b1;
      repeat (TAP_COUNT + 10) send_sample(24'sh7FFFFF);
      no_idle = 1'b0;
      repeat (TAP_COUNT + 10) send_sample(24'sh800000);
   endtask

   task automatic test_pause_until_drained();
      send_sample(24'sd4096);
      wait_drained();
      send_sample(-24'sd4096);
   endtask

   task automatic test_random(input int unsigned count);
      logic signed [SAMPLE_W-1:0] sample;
      int                         step;
      for (int unsigned i = 0; i < count; i++) begin
         no_idle = (i >= count / 3) && (i < count / 2);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               sample = SAMPLE_W'($urandom);
            end
            5, 6: begin
               step   = int'($urandom_range(511)) - 256;
               sample = SAMPLE_W'(step * 32768);
            end
            7: begin
               step   = int'($urandom_range(15));
               sample = $urandom_range(1) ? SAMPLE_W'(8388607 - step)
                                          : SAMPLE_W'(-8388608 + step);
            end
            default: begin
               sample = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
            end
         endcase
         send_sample(sample);
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            stuck_cycles <= 0;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_filtered.size() == 0) begin
               if (mismatches < REPORT_MAX) begin
                  $display("unexpected result beat: filtered %0d", rsp_filtered);
               end
               mismatches++;
            end else begin
               if (rsp_filtered !== expected_filtered[0]) begin
                  if (mismatches < REPORT_MAX) begin
                     $display("filtered mismatch: expected %0d, got %0d",
                              expected_filtered[0], rsp_filtered);
                  end
                  mismatches++;
               end
               void'(expected_filtered.pop_front());
            end
         end
         rsp_stall <= take_idle();
      end
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
      end
      $display("fir_lowpass_filter_top verification failed");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sample   <= '0;
      no_idle      = 1'b0;
      history_head = 0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         sample_history[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_rounding_ties();
      test_extremes();
      test_saturation();
      test_pause_until_drained();
      test_random(560);

      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_filtered.size() == 0) begin
         $display("fir_lowpass_filter_top verification clean");
      end else begin
         $display("fir_lowpass_filter_top verification failed");
      end
      $finish;
   end

endmodule
